### sv/ugbq_pkg.sv
// ----------------------------------------------------------------------------
// ugbq_pkg
// Shared types, codes and constants of the uniform grid box query block.
// ----------------------------------------------------------------------------
package ugbq_pkg;

	localparam int MAX_OBJECTS_DEF = 64;
	localparam int COORD_BITS_DEF  = 16;
	localparam int CFG_BITS        = 16;
	localparam int CFG_IDX_BITS    = 3;
	localparam int SIZE_BITS       = 15;
	localparam int ID_BITS         = 6;
	localparam int TAG_BITS        = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_STORED     = 3'd1,
		ST_NOT_STORED = 3'd2,
		ST_BAD_BOX    = 3'd3,
		ST_OUTSIDE    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CFG_LEFT   = 3'd0,
		CFG_RIGHT  = 3'd1,
		CFG_BOTTOM = 3'd2,
		CFG_TOP    = 3'd3,
		CFG_SIZE   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_SCAN_WAIT,
		S_DONE
	} fsm_t;

endpackage

### sv/ugbq_div.sv
// ----------------------------------------------------------------------------
// ugbq_div
// Floor division of a signed value by an unsigned cell size, one quotient
// bit per cycle (restoring division on the dividend, inverted if negative).
// ----------------------------------------------------------------------------
module ugbq_div #(
	parameter int W = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [W-1:0]           dividend,
	input  logic [ugbq_pkg::SIZE_BITS-1:0] divisor,
	output logic                          done,
	output logic signed [W-1:0]           quotient
);
	import ugbq_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  num_q;
	logic [W-1:0]  quo_q;
	logic [W:0]    rem_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          run_q;
	logic [W:0]    trial;
	logic [W:0]    dsor;
	logic [W-1:0]  mag;

	// negative a: floor(a/s) = -((-a-1)/s) - 1 = ~((~a)/s)
	assign mag  = dividend[W-1] ? ~dividend : dividend;
	assign dsor = (divisor == '0) ? (W+1)'(1) : (W+1)'(divisor);
	assign trial = {rem_q[W-1:0], num_q[W-1]};

	// shift one dividend bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= mag;
			neg_q <= dividend[W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (trial >= dsor) begin
				rem_q <= trial - dsor;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? ~quo_q : quo_q;

endmodule

### sv/ugbq_store.sv
// ----------------------------------------------------------------------------
// ugbq_store
// Object slot memory: box and tag per slot, one write and one registered read
// a cycle; stored flags in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module ugbq_store #(
	parameter int MAX_OBJECTS = 64,
	parameter int COORD_BITS  = 16,
	parameter int AW          = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [4*COORD_BITS-1:0]         wbox,
	input  logic                            wtag_en,
	input  logic [ugbq_pkg::TAG_BITS-1:0]   wtag,
	input  logic                            flag_we,
	input  logic                            flag_val,
	input  logic [AW-1:0]                   raddr,
	output logic [4*COORD_BITS-1:0]         rbox,
	output logic [ugbq_pkg::TAG_BITS-1:0]   rtag,
	output logic                            rstored,
	output logic                            wstored
);
	import ugbq_pkg::*;

	logic [4*COORD_BITS-1:0] box_mem [MAX_OBJECTS];
	logic [TAG_BITS-1:0]     tag_mem [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0]  stored_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			box_mem[waddr] <= wbox;
		if (wtag_en)
			tag_mem[waddr] <= wtag;
		rbox <= box_mem[raddr];
		rtag <= tag_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			rstored  <= 1'b0;
		end else begin
			if (flag_we)
				stored_q[waddr] <= flag_val;
			rstored <= stored_q[raddr];
		end
	end

	assign wstored = stored_q[waddr];

endmodule

### sv/uniform_grid_box_query.sv
// ----------------------------------------------------------------------------
// uniform_grid_box_query
// Broad-phase uniform grid over up to MAX_OBJECTS axis-aligned boxes.
// ----------------------------------------------------------------------------
// Use: raise start with a request on the input ports while busy is low; the
// item is taken at that edge and busy stays high until its last result is out.
// Add, remove and update give one result (strobe high, last high), registered
// on leaving S_DONE. A lookup with an invalid box skips the divisions and goes
// from S_DIV straight to S_DONE to answer. Any other lookup first runs eight
// floor divisions by cell_size on one shared bit-serial divider, then visits
// every slot of the object memory in turn (read in S_SCAN, then test in
// S_SCAN_WAIT). A slot that is stored and whose box touches the query box needs
// four more divisions for its cell range. busy falls in the cycle the final
// result is shown, so a new item can follow at once.
// Hits come out on strobe in ascending slot order, last on the final one; a
// lookup with no hit gives one result with hit_valid low. Results are shown
// for one cycle and cannot be stalled. Reset clears all stored flags and
// restores the register defaults; no clearing pass is run. The user must write
// configuration through cfg_we/cfg_index/cfg_data while idle; it is not enforced.
// ----------------------------------------------------------------------------
module uniform_grid_box_query #(
	parameter int MAX_OBJECTS = ugbq_pkg::MAX_OBJECTS_DEF,
	parameter int COORD_BITS  = ugbq_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [ugbq_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [ugbq_pkg::CFG_BITS-1:0]     cfg_data,
	input  logic [1:0]                        req_type,
	input  logic [ugbq_pkg::ID_BITS-1:0]      object_id,
	input  logic [ugbq_pkg::TAG_BITS-1:0]     user_tag,
	input  logic signed [COORD_BITS-1:0]      box_left,
	input  logic signed [COORD_BITS-1:0]      box_right,
	input  logic signed [COORD_BITS-1:0]      box_bottom,
	input  logic signed [COORD_BITS-1:0]      box_top,
	output logic                              strobe,
	output logic [2:0]                        status,
	output logic                              hit_valid,
	output logic [ugbq_pkg::ID_BITS-1:0]      hit_id,
	output logic [ugbq_pkg::TAG_BITS-1:0]     hit_tag,
	output logic                              last
);
	import ugbq_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = C + 2;
	localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

	fsm_t state_q, state_d;

	// configuration registers
	logic signed [C-1:0]   a_l_q, a_r_q, a_b_q, a_t_q;
	logic [SIZE_BITS-1:0]  size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_l_q  <= C'(-1024);
			a_r_q  <= C'(1024);
			a_b_q  <= C'(-1024);
			a_t_q  <= C'(1024);
			size_q <= SIZE_BITS'(64);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LEFT:   a_l_q  <= C'(signed'(cfg_data));
				CFG_RIGHT:  a_r_q  <= C'(signed'(cfg_data));
				CFG_BOTTOM: a_b_q  <= C'(signed'(cfg_data));
				CFG_TOP:    a_t_q  <= C'(signed'(cfg_data));
				CFG_SIZE:   size_q <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// latched request
	req_t                req_q;
	logic [ID_BITS-1:0]  id_q;
	logic [TAG_BITS-1:0] tag_q;
	logic signed [C-1:0] ql_q, qr_q, qb_q, qt_q;

	logic accept;
	logic in_bad;
	assign accept = start && !busy;
	assign in_bad = (box_left > box_right) || (box_bottom > box_top);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			id_q  <= object_id;
			tag_q <= user_tag;
			ql_q  <= box_left;
			qr_q  <= box_right;
			qb_q  <= box_bottom;
			qt_q  <= box_top;
		end
	end

	// memory
	logic              mem_we, flag_we, flag_val, rstored, wstored;
	logic [AW-1:0]     waddr, raddr;
	logic [4*C-1:0]    rbox;
	logic [TAG_BITS-1:0] rtag;

	assign waddr = id_q[AW-1:0];

	ugbq_store #(.MAX_OBJECTS(MAX_OBJECTS), .COORD_BITS(C), .AW(AW)) u_store (
		.clk(clk), .arst_n(arst_n),
		.we(mem_we), .waddr(waddr), .wbox({ql_q, qr_q, qb_q, qt_q}),
		.wtag_en(mem_we && req_q == REQ_ADD), .wtag(tag_q),
		.flag_we(flag_we), .flag_val(flag_val),
		.raddr(raddr), .rbox(rbox), .rtag(rtag), .rstored(rstored), .wstored(wstored)
	);

	// divider
	logic signed [DW-1:0] dnum, dquo;
	logic                 ddone;

	// division sequencing: steps 0..7 for grid and query, 8..11 per object
	logic [3:0]           step_q;
	logic signed [DW-1:0] cell_q [12];
	logic signed [C-1:0]  ol_q, or_q, ob_q, ot_q;
	logic [TAG_BITS-1:0]  otag_q;
	logic [AW:0]          slot_q;
	logic                 dstart_q;

	ugbq_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .dividend(dnum),
		.divisor(size_q), .done(ddone), .quotient(dquo)
	);

	always_comb begin
		unique case (step_q)
			4'd0:    dnum = DW'(a_l_q);
			4'd1:    dnum = DW'(a_r_q) - DW'(1);
			4'd2:    dnum = DW'(a_b_q);
			4'd3:    dnum = DW'(a_t_q) - DW'(1);
			4'd4:    dnum = DW'(ql_q);
			4'd5:    dnum = DW'(qr_q) - DW'(1);
			4'd6:    dnum = DW'(qb_q);
			4'd7:    dnum = DW'(qt_q) - DW'(1);
			4'd8:    dnum = DW'(ol_q);
			4'd9:    dnum = DW'(or_q) - DW'(1);
			4'd10:   dnum = DW'(ob_q);
			default: dnum = DW'(ot_q) - DW'(1);
		endcase
	end

	// clamped query cell range
	logic signed [DW-1:0] cl, cr, cb, ct;
	always_comb begin
		cl = (cell_q[4] > cell_q[0]) ? cell_q[4] : cell_q[0];
		cr = (cell_q[5] < cell_q[1]) ? cell_q[5] : cell_q[1];
		cb = (cell_q[6] > cell_q[2]) ? cell_q[6] : cell_q[2];
		ct = (cell_q[7] < cell_q[3]) ? cell_q[7] : cell_q[3];
	end

	// object tests
	logic box_bad, out_area, ov_box, ov_cell;
	logic signed [C-1:0] rl, rr, rb, rt;
	assign {rl, rr, rb, rt} = rbox;
	assign box_bad  = (ql_q > qr_q) || (qb_q > qt_q);
	assign out_area = (ql_q < a_l_q) || (qr_q > a_r_q) || (qb_q < a_b_q) || (qt_q > a_t_q);
	assign ov_box   = !((rr < ql_q) || (rl > qr_q) || (rt < qb_q) || (rb > qt_q));
	assign ov_cell  = !(((cell_q[8] > cl) ? cell_q[8] : cl) > ((cell_q[9] < cr) ? cell_q[9] : cr)
		|| ((cell_q[10] > cb) ? cell_q[10] : cb) > ((cell_q[11] < ct) ? cell_q[11] : ct));

	logic any_hit_q;
	logic pend_v_q;
	logic [ID_BITS-1:0] pend_id_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	logic obj_div_q;
	status_t st_d;

	assign raddr = slot_q[AW-1:0];
	assign busy  = state_q != S_IDLE;

	// status and memory writes for maintenance items
	always_comb begin
		st_d     = ST_OK;
		mem_we   = 1'b0;
		flag_we  = 1'b0;
		flag_val = 1'b0;
		if (32'(id_q) >= MAX_OBJECTS)
			st_d = ST_NOT_STORED;
		else begin
			unique case (req_q)
				REQ_ADD: begin
					if (wstored) st_d = ST_STORED;
					else if (box_bad) st_d = ST_BAD_BOX;
					else if (out_area) st_d = ST_OUTSIDE;
					else begin
						mem_we = 1'b1; flag_we = 1'b1; flag_val = 1'b1;
					end
				end
				REQ_REMOVE: begin
					if (!wstored) st_d = ST_NOT_STORED;
					else flag_we = 1'b1;
				end
				REQ_UPDATE: begin
					if (!wstored) st_d = ST_NOT_STORED;
					else if (box_bad) st_d = ST_BAD_BOX;
					else if (out_area) st_d = ST_OUTSIDE;
					else mem_we = 1'b1;
				end
				default: ;
			endcase
		end
		if (state_q != S_DONE || req_q == REQ_LOOKUP) begin
			mem_we  = 1'b0;
			flag_we = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = (req_type == REQ_LOOKUP) ? S_DIV : S_DONE;
			S_DIV: begin
				if (req_q == REQ_LOOKUP && box_bad) state_d = S_DONE;
				else if (ddone && step_q == 4'd7) state_d = S_SCAN;
			end
			S_SCAN: state_d = S_SCAN_WAIT;
			S_SCAN_WAIT: begin
				if (obj_div_q) begin
					if (ddone && step_q == 4'd11) state_d = S_SCAN;
				end else if (slot_q == (AW+1)'(MAX_OBJECTS)) state_d = S_DONE;
				else state_d = S_SCAN;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// sequencer datapath: advance divisions, scan slots, emit hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			dstart_q   <= 1'b0;
			slot_q     <= '0;
			obj_div_q  <= 1'b0;
			any_hit_q  <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_id_q  <= '0;
			pend_tag_q <= '0;
			cell_q     <= '{default: '0};
			ol_q       <= '0;
			or_q       <= '0;
			ob_q       <= '0;
			ot_q       <= '0;
			otag_q     <= '0;
			strobe     <= 1'b0;
			status     <= '0;
			hit_valid  <= 1'b0;
			hit_id     <= '0;
			hit_tag    <= '0;
			last       <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			strobe   <= 1'b0;
			if (accept) begin
				step_q    <= '0;
				// an invalid query box skips the divisions
				dstart_q  <= (req_type == REQ_LOOKUP) && !in_bad;
				slot_q    <= '0;
				obj_div_q <= 1'b0;
				any_hit_q <= 1'b0;
				pend_v_q  <= 1'b0;
			end
			if (ddone) begin
				cell_q[step_q] <= dquo;
				if (step_q != 4'd7 && step_q != 4'd11) begin
					step_q   <= step_q + 1'b1;
					dstart_q <= 1'b1;
				end
			end
			// slot read issued in S_SCAN, data seen in S_SCAN_WAIT
			if (state_q == S_SCAN_WAIT && !obj_div_q && slot_q != (AW+1)'(MAX_OBJECTS)) begin
				if (rstored && ov_box) begin
					{ol_q, or_q, ob_q, ot_q} <= rbox;
					otag_q    <= rtag;
					obj_div_q <= 1'b1;
					step_q    <= 4'd8;
					dstart_q  <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (state_q == S_SCAN_WAIT && obj_div_q && ddone && step_q == 4'd11) begin
				obj_div_q <= 1'b0;
				slot_q    <= slot_q + 1'b1;
			end
			// a finished candidate: test cells in the cycle after its last division
			if (state_q == S_SCAN && step_q == 4'd11 && ov_cell && slot_q != '0) begin
				if (pend_v_q) begin
					strobe    <= 1'b1;
					status    <= ST_OK;
					hit_valid <= 1'b1;
					hit_id    <= pend_id_q;
					hit_tag   <= pend_tag_q;
					last      <= 1'b0;
				end
				pend_v_q   <= 1'b1;
				pend_id_q  <= ID_BITS'(slot_q - 1'b1);
				pend_tag_q <= otag_q;
				any_hit_q  <= 1'b1;
				step_q     <= 4'd7;
			end else if (state_q == S_SCAN && step_q == 4'd11) begin
				step_q <= 4'd7;
			end
			if (state_q == S_DONE) begin
				strobe <= 1'b1;
				last   <= 1'b1;
				if (req_q != REQ_LOOKUP) begin
					status <= st_d; hit_valid <= 1'b0; hit_id <= '0; hit_tag <= '0;
				end else if (box_bad) begin
					status <= ST_BAD_BOX; hit_valid <= 1'b0; hit_id <= '0; hit_tag <= '0;
				end else if (pend_v_q) begin
					status <= ST_OK; hit_valid <= 1'b1; hit_id <= pend_id_q;
					hit_tag <= pend_tag_q;
				end else begin
					status <= ST_OK; hit_valid <= 1'b0; hit_id <= '0; hit_tag <= '0;
				end
			end
		end
	end

endmodule

### sv/ugbq_checker.sv
// ----------------------------------------------------------------------------
// ugbq_checker
// Port-level checks of the uniform grid box query block, bound to the top.
// ----------------------------------------------------------------------------
module ugbq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic       hit_valid,
	input logic       last,
	input logic [2:0] status
);
	import ugbq_pkg::*;

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item taken but block idle");

	// a hit always carries status ok
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && hit_valid |-> status == ST_OK) else $error("hit with error status");

	// the block is idle in the cycle its final result is shown
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy) else $error("busy after last result");

	// no result while idle except the final one
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("stray result");

endmodule

bind uniform_grid_box_query ugbq_checker u_ugbq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.hit_valid(hit_valid), .last(last), .status(status)
);
